// ===== src/urx_pkg.sv =====
package urx_pkg;

   localparam int STOP_LIMIT_W = 8;
   localparam int QLEN_W       = 7;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;
   localparam int AVAIL_W      = 6;

   localparam logic [STOP_LIMIT_W-1:0] RST_STOP_WAIT_LIMIT = 8'd18;
   localparam logic [QLEN_W-1:0]       RST_QUEUE_LENGTH    = 7'd64;
   localparam logic [3:0]              STOP_POSITION       = 4'd9;
   localparam logic [3:0]              FIRST_DATA_POSITION = 4'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_WAIT_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_LENGTH    = 4'd1;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_PEEK  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic       rx_level;
   } req_type;

   typedef struct packed {
      logic [7:0]         rx_data;
      logic               data_valid;
      logic [AVAIL_W-1:0] available;
      logic               frame_error;
      logic               overflow;
      logic               receiving;
   } rsp_type;

   // what the frame receiver hands to the fifo for one request
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       frame_error;
      logic       receiving;
   } frame_evt_type;

   // fifo status for one request, read data follows in the next cycle
   typedef struct packed {
      logic               data_valid;
      logic               use_mem;
      logic [AVAIL_W-1:0] available;
      logic               overflow;
   } fifo_stat_type;

endpackage

// ===== src/uart_receiver_with_fifo_top.sv =====
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_data  (operation, rx_level)
// rsp     | out       | rsp_valid/rsp_ready | rsp_data  (rx_data .. receiving)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// one request per cycle while req_ready is high; its response is registered
// in s1 and the output register, the fifo ram read sets the extra stage
// after reset the whole ram (FIFO_DEPTH entries) is zeroed with req_ready low
// a clear request zeroes the ring over its effective length, req_ready low
// a stalled response holds in the output register, one more request is
// taken into the stage behind it
module uart_receiver_with_fifo_top #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  urx_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output urx_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [urx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [urx_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import urx_pkg::*;

   logic [STOP_LIMIT_W-1:0] stop_wait_limit_ff;
   logic [QLEN_W-1:0]       queue_length_ff;
   logic                    accept, busy;
   frame_evt_type           evt;
   fifo_stat_type           stat;
   logic [7:0]              rd_data;

   logic          s1_valid_ff, s1_valid_in;
   fifo_stat_type s1_stat_ff;
   logic          s1_ferr_ff, s1_recv_ff;
   logic          s1_adv;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_wait_limit_ff <= RST_STOP_WAIT_LIMIT;
         queue_length_ff    <= RST_QUEUE_LENGTH;
      end else if (csr_valid) begin
         if (csr_index == CSR_STOP_WAIT_LIMIT) stop_wait_limit_ff <= csr_wdata;
         else if (csr_index == CSR_QUEUE_LENGTH) queue_length_ff <= csr_wdata[QLEN_W-1:0];
      end
   end

   assign s1_adv    = !out_valid_ff || rsp_ready;
   assign req_ready = !busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   urx_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req             (req_data),
      .stop_wait_limit (stop_wait_limit_ff),
      .evt             (evt)
   );

   urx_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_data.operation),
      .evt          (evt),
      .queue_length (queue_length_ff),
      .stat         (stat),
      .rd_data      (rd_data),
      .busy         (busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)      s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (s1_valid_ff && s1_adv) out_valid_in = 1'b1;
      else if (rsp_ready)        out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= stat;
         s1_ferr_ff <= evt.frame_error;
         s1_recv_ff <= evt.receiving;
      end
      if (s1_valid_ff && s1_adv) begin
         // ram data lands the cycle after acceptance
         out_ff.rx_data     <= s1_stat_ff.use_mem ? rd_data : 8'd0;
         out_ff.data_valid  <= s1_stat_ff.data_valid;
         out_ff.available   <= s1_stat_ff.available;
         out_ff.frame_error <= s1_ferr_ff;
         out_ff.overflow    <= s1_stat_ff.overflow;
         out_ff.receiving   <= s1_recv_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== src/urx_frame.sv =====
module urx_frame (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  urx_pkg::req_type                req,
   input  logic [urx_pkg::STOP_LIMIT_W-1:0] stop_wait_limit,
   output urx_pkg::frame_evt_type          evt
);
   import urx_pkg::*;

   logic [3:0]              bit_pos_ff, bit_pos_in;
   logic [7:0]              shift_ff, shift_in;
   logic [STOP_LIMIT_W-1:0] stop_cnt_ff, stop_cnt_in;
   logic [2:0]              bit_sel;

   assign bit_sel = 3'(bit_pos_ff - 4'd1);

   always_comb begin
      bit_pos_in      = bit_pos_ff;
      shift_in        = shift_ff;
      stop_cnt_in     = stop_cnt_ff;
      evt.push        = 1'b0;
      evt.push_byte   = shift_ff;
      evt.frame_error = 1'b0;
      unique case (req.operation)
         OP_START: begin
            if (bit_pos_ff == 4'd0 && !req.rx_level) begin
               bit_pos_in = FIRST_DATA_POSITION;
               shift_in   = 8'd0;
            end else begin
               evt.frame_error = 1'b1;
            end
         end
         OP_TICK: begin
            if (bit_pos_ff == 4'd0) begin
               // idle, tick ignored
            end else if (bit_pos_ff < STOP_POSITION) begin
               if (req.rx_level) shift_in[bit_sel] = 1'b1;
               bit_pos_in = bit_pos_ff + 4'd1;
            end else if (req.rx_level) begin
               stop_cnt_in = '0;
               evt.push    = 1'b1;
               bit_pos_in  = 4'd0;
            end else if (stop_cnt_ff >= stop_wait_limit) begin
               // stop wait exhausted, abort the frame
               stop_cnt_in     = '0;
               evt.frame_error = 1'b1;
               bit_pos_in      = 4'd0;
            end else begin
               stop_cnt_in = stop_cnt_ff + STOP_LIMIT_W'(1);
            end
         end
         default: begin
         end
      endcase
      evt.receiving = (bit_pos_in != 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff  <= 4'd0;
         stop_cnt_ff <= '0;
      end else if (accept) begin
         bit_pos_ff  <= bit_pos_in;
         stop_cnt_ff <= stop_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) shift_ff <= shift_in;
   end

endmodule

// ===== src/urx_fifo.sv =====
module urx_fifo #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                operation,
   input  urx_pkg::frame_evt_type    evt,
   input  logic [urx_pkg::QLEN_W-1:0] queue_length,
   output urx_pkg::fifo_stat_type    stat,
   output logic [7:0]                rd_data,
   output logic                      busy
);
   import urx_pkg::*;

   localparam int IW = $clog2(FIFO_DEPTH);
   localparam int LW = $clog2(FIFO_DEPTH + 1);
   localparam int CW = ((LW > QLEN_W) ? LW : QLEN_W) + 1;
   localparam int SW = (LW > AVAIL_W) ? LW : AVAIL_W + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
   localparam logic [SW-1:0] AVAIL_MAX = SW'((1 << AVAIL_W) - 1);

   logic [7:0]    mem [FIFO_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [IW-1:0] wi_ff, wi_in, ri_ff, ri_in;
   logic [IW-1:0] wi_n, ri_n, wi_inc, ri_inc;
   logic [LW-1:0] len, count, count_in;
   logic [CW-1:0] qlen_ext, len_c;
   logic [SW-1:0] count_ext;
   logic          full, do_push, do_read, do_peek, do_clear;
   logic          sweep_ff, sweep_in;
   logic [LW-1:0] sweep_cnt_ff, sweep_cnt_in, sweep_end_ff, sweep_end_in;
   logic          we;
   logic [IW-1:0] waddr;
   logic [7:0]    wdata;

   // effective ring length, clamped to 2..depth
   always_comb begin
      qlen_ext = CW'(queue_length);
      if (qlen_ext < CW'(2))       len_c = CW'(2);
      else if (qlen_ext > DEPTH_C) len_c = DEPTH_C;
      else                         len_c = qlen_ext;
      len = LW'(len_c);
   end

   // indices beyond a shrunk length fall back to zero
   assign wi_n = (LW'(wi_ff) >= len) ? '0 : wi_ff;
   assign ri_n = (LW'(ri_ff) >= len) ? '0 : ri_ff;
   assign wi_inc = (LW'(wi_n) + LW'(1) >= len) ? '0 : IW'(LW'(wi_n) + LW'(1));
   assign ri_inc = (LW'(ri_n) + LW'(1) >= len) ? '0 : IW'(LW'(ri_n) + LW'(1));

   assign count = (wi_n >= ri_n) ? LW'(wi_n) - LW'(ri_n)
                                 : len + LW'(wi_n) - LW'(ri_n);
   assign full  = (count >= len - LW'(1));

   assign do_push  = (operation == OP_TICK) && evt.push && !full;
   assign do_read  = (operation == OP_READ) && (count != '0);
   assign do_peek  = (operation == OP_PEEK);
   assign do_clear = (operation == OP_CLEAR);

   always_comb begin
      wi_in    = wi_n;
      ri_in    = ri_n;
      count_in = count;
      if (do_clear) begin
         wi_in    = '0;
         ri_in    = '0;
         count_in = '0;
      end else if (do_push) begin
         wi_in    = wi_inc;
         count_in = count + LW'(1);
      end else if (do_read) begin
         ri_in    = ri_inc;
         count_in = count - LW'(1);
      end
   end

   always_comb begin
      count_ext       = SW'(count_in);
      stat.available  = (count_ext > AVAIL_MAX) ? AVAIL_MAX[AVAIL_W-1:0]
                                                : count_ext[AVAIL_W-1:0];
      stat.data_valid = do_read;
      stat.use_mem    = do_read || do_peek;
      stat.overflow   = (operation == OP_TICK) && evt.push && full;
   end

   // zeroing sweep after reset and on clear, one entry a cycle
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      sweep_end_in = sweep_end_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + LW'(1);
         if (sweep_cnt_in == sweep_end_ff) sweep_in = 1'b0;
      end else if (accept && do_clear) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
         sweep_end_in = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         sweep_end_ff <= LW'(FIFO_DEPTH);
         wi_ff        <= '0;
         ri_ff        <= '0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_end_ff <= sweep_end_in;
         if (accept) begin
            wi_ff <= wi_in;
            ri_ff <= ri_in;
         end
      end
   end

   assign we    = sweep_ff || (accept && do_push);
   assign waddr = sweep_ff ? sweep_cnt_ff[IW-1:0] : wi_n;
   assign wdata = sweep_ff ? 8'd0 : evt.push_byte;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (accept && stat.use_mem) rd_data_ff <= mem[ri_n];
   end

   assign rd_data = rd_data_ff;
   assign busy    = sweep_ff;

endmodule

// ===== src/urx_checker.sv =====
module urx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input urx_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input urx_pkg::rsp_type rsp_data
);
   import urx_pkg::*;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // ram zeroing keeps requests out right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during reset sweep");

   // a clear request starts a sweep that blocks the next request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_CLEAR |=> !req_ready)
      else $error("request taken during clear sweep");

   // error, overflow and popped data come from different events
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frame_error && rsp_data.overflow) &&
                    !(rsp_data.data_valid && (rsp_data.frame_error || rsp_data.overflow)))
      else $error("conflicting response flags");

endmodule

bind uart_receiver_with_fifo_top urx_checker u_urx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
